[sv/qsps_pkg.sv]
// Package for the queued solenoid pulse sequencer.
// Holds sizes, field widths, codes, state types and the controller/datapath structs.
// No dependencies; every other file of the block imports it.
`default_nettype none
package qsps_pkg;

	localparam int NUM_LOCKS   = 4;
	localparam int TIMER_WIDTH = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int MASK_W      = 4;
	localparam int SDATA_W     = 8;
	localparam int MDATA_W     = 16;
	localparam int OUT_MASK_W  = 4;
	localparam int OUT_ID_W    = 3;
	localparam int ID_W        = $clog2(NUM_LOCKS + 1);
	localparam int LIDX_W      = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
	localparam int CMP_W       = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
	localparam int OUT_LOCKS   = (NUM_LOCKS < OUT_MASK_W) ? NUM_LOCKS : OUT_MASK_W;

	localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETWEEN_TICKS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SELF_LOCK_TICKS = 2'd2;

	localparam logic [CFG_W-1:0] PULSE_TICKS_RST     = 16'd2;
	localparam logic [CFG_W-1:0] BETWEEN_TICKS_RST   = 16'd6;
	localparam logic [CFG_W-1:0] SELF_LOCK_TICKS_RST = 16'd20;

	typedef enum logic {
		OP_TICK   = 1'b0,
		OP_UNLOCK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PH_WAIT_TURN = 2'd0,
		PH_WAIT_COOL = 2'd1,
		PH_PULSE     = 2'd2,
		PH_RELEASE   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_STEP = 2'd1,
		ST_DONE = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		logic              load_in;
		logic              exec;
		logic [LIDX_W-1:0] idx;
		logic              load_out;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} sts_t;

	function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
		sat_inc = (v == {TIMER_WIDTH{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic reached(input logic [TIMER_WIDTH-1:0] cnt,
		input logic [CFG_W-1:0] lim);
		reached = CMP_W'(cnt) >= CMP_W'(lim);
	endfunction

endpackage
`default_nettype wire

[sv/qsps_ctrl.sv]
// Controller of the queued solenoid pulse sequencer.
// Sequences item intake, one lock step per cycle and the result load.
// Depends on qsps_pkg.
`default_nettype none
module qsps_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic         m_tready,
	input  wire qsps_pkg::sts_t sts,
	output qsps_pkg::cmd_t    cmd
);
	import qsps_pkg::*;

	ctrl_state_t       state_q, state_nxt;
	logic [LIDX_W-1:0] idx_q;
	logic              last_step;

	assign last_step = (idx_q == LIDX_W'(NUM_LOCKS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_STEP && !last_step) begin
				idx_q <= idx_q + 1'b1;
			end else if (state_q != ST_STEP) begin
				idx_q <= '0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_STEP;
			end
			ST_STEP: begin
				if (last_step) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_full || m_tready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.load_in  = 1'b0;
		cmd.exec     = 1'b0;
		cmd.idx      = idx_q;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			ST_STEP: cmd.exec = 1'b1;
			ST_DONE: cmd.load_out = !sts.out_full || m_tready;
			default: ;
		endcase
	end

	a_step_idx_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (idx_q == '0))
		else $error("lock index not cleared outside the step phase");

endmodule
`default_nettype wire

[sv/qsps_dp.sv]
// Datapath of the queued solenoid pulse sequencer.
// Holds configuration, the request queue, per-lock timers and the result register.
// Depends on qsps_pkg; driven by qsps_ctrl through cmd_t/sts_t.
`default_nettype none
module qsps_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [qsps_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [qsps_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic [qsps_pkg::SDATA_W-1:0]   s_tdata,
	input  wire logic                           s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [qsps_pkg::MDATA_W-1:0]        m_tdata,
	input  wire qsps_pkg::cmd_t                 cmd,
	output qsps_pkg::sts_t                      sts
);
	import qsps_pkg::*;

	logic [CFG_W-1:0] pulse_ticks_q, between_ticks_q, self_lock_ticks_q;

	op_t               op_q;
	logic [MASK_W-1:0] mask_q;

	phase_t                 ph_q   [NUM_LOCKS];
	logic [TIMER_WIDTH-1:0] pe_q   [NUM_LOCKS];
	logic [TIMER_WIDTH-1:0] re_q   [NUM_LOCKS];
	logic [TIMER_WIDTH-1:0] ce_q   [NUM_LOCKS];
	logic [NUM_LOCKS-1:0]   ca_q;
	logic [NUM_LOCKS-1:0]   dl_q;
	logic [ID_W-1:0]        qid_q  [NUM_LOCKS];
	logic [ID_W-1:0]        fill_q;

	logic                  out_valid_q;
	logic [OUT_MASK_W-1:0] out_drive_q, out_cool_q;
	logic [OUT_ID_W-1:0]   out_cnt_q, out_head_q;

	phase_t                 ph_n;
	logic [TIMER_WIDTH-1:0] pe_n, re_n, ce_n;
	logic                   ca_n, dl_n;
	logic [ID_W-1:0]        qid_n [NUM_LOCKS];
	logic [ID_W-1:0]        fill_n;

	always_comb begin
		logic            cs;
		logic            queued;
		logic            req;
		logic [ID_W-1:0] id;
		ph_n   = ph_q[cmd.idx];
		pe_n   = pe_q[cmd.idx];
		re_n   = re_q[cmd.idx];
		ce_n   = ce_q[cmd.idx];
		ca_n   = ca_q[cmd.idx];
		dl_n   = dl_q[cmd.idx];
		qid_n  = qid_q;
		fill_n = fill_q;
		cs     = 1'b0;
		queued = 1'b0;
		req    = 1'b0;
		id     = ID_W'(cmd.idx) + 1'b1;
		if (op_q == OP_UNLOCK) begin
			for (int j = 0; j < MASK_W; j++) begin
				if (LIDX_W'(j) == cmd.idx && j < NUM_LOCKS) req = mask_q[j];
			end
			for (int i = 0; i < NUM_LOCKS; i++) begin
				if (ID_W'(i) < fill_q && qid_q[i] == id) queued = 1'b1;
			end
			if (req && !queued && fill_q < ID_W'(NUM_LOCKS)) begin
				for (int i = 0; i < NUM_LOCKS; i++) begin
					if (ID_W'(i) == fill_q) qid_n[i] = id;
				end
				fill_n = fill_q + 1'b1;
			end
		end else begin
			if (ph_n == PH_PULSE) begin
				pe_n = sat_inc(pe_n);
				re_n = sat_inc(re_n);
			end else if (ph_n == PH_RELEASE) begin
				re_n = sat_inc(re_n);
			end
			if (ph_n == PH_WAIT_TURN && fill_q != '0 && qid_q[0] == id) begin
				ph_n = PH_WAIT_COOL;
			end
			if (ph_n == PH_WAIT_COOL && !ca_n) begin
				dl_n = 1'b1;
				pe_n = '0;
				re_n = '0;
				ph_n = PH_PULSE;
				if (reached('0, pulse_ticks_q)) begin
					dl_n = 1'b0;
					ca_n = 1'b1;
					ce_n = '0;
					cs   = 1'b1;
					ph_n = PH_RELEASE;
				end
			end else if (ph_n == PH_PULSE) begin
				if (reached(pe_n, pulse_ticks_q)) begin
					dl_n = 1'b0;
					ca_n = 1'b1;
					ce_n = '0;
					cs   = 1'b1;
					ph_n = PH_RELEASE;
				end
			end else if (ph_n == PH_RELEASE) begin
				if (reached(re_n, between_ticks_q)) begin
					if (fill_q != '0) begin
						for (int i = 1; i < NUM_LOCKS; i++) begin
							if (ID_W'(i) < fill_q) qid_n[i-1] = qid_q[i];
						end
						fill_n = fill_q - 1'b1;
						for (int i = 0; i < NUM_LOCKS; i++) begin
							if (ID_W'(i) == fill_n) qid_n[i] = '0;
						end
					end
					pe_n = '0;
					re_n = '0;
					ph_n = PH_WAIT_TURN;
				end
			end
			if (ca_n) begin
				if (!cs) ce_n = sat_inc(ce_n);
				if (reached(ce_n, self_lock_ticks_q)) begin
					ca_n = 1'b0;
					ce_n = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_ticks_q     <= PULSE_TICKS_RST;
			between_ticks_q   <= BETWEEN_TICKS_RST;
			self_lock_ticks_q <= SELF_LOCK_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PULSE_TICKS:     pulse_ticks_q     <= cfg_data;
				REG_BETWEEN_TICKS:   between_ticks_q   <= cfg_data;
				REG_SELF_LOCK_TICKS: self_lock_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= op_t'(s_tuser);
			mask_q <= s_tdata[MASK_W-1:0];
		end
		if (cmd.load_out) begin
			for (int j = 0; j < OUT_MASK_W; j++) begin
				out_drive_q[j] <= (j < OUT_LOCKS) ? dl_q[j] : 1'b0;
				out_cool_q[j]  <= (j < OUT_LOCKS) ? ca_q[j] : 1'b0;
			end
			out_cnt_q  <= OUT_ID_W'(fill_q);
			out_head_q <= (fill_q != '0) ? OUT_ID_W'(qid_q[0]) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_LOCKS; k++) begin
				ph_q[k]  <= PH_WAIT_TURN;
				pe_q[k]  <= '0;
				re_q[k]  <= '0;
				ce_q[k]  <= '0;
				qid_q[k] <= '0;
			end
			ca_q        <= '0;
			dl_q        <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				qid_q  <= qid_n;
				fill_q <= fill_n;
				if (op_q == OP_TICK) begin
					ph_q[cmd.idx] <= ph_n;
					pe_q[cmd.idx] <= pe_n;
					re_q[cmd.idx] <= re_n;
					ce_q[cmd.idx] <= ce_n;
					ca_q[cmd.idx] <= ca_n;
					dl_q[cmd.idx] <= dl_n;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_full = out_valid_q;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = {{(MDATA_W - 2*OUT_MASK_W - 2*OUT_ID_W){1'b0}},
		out_cool_q, out_head_q, out_cnt_q, out_drive_q};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= ID_W'(NUM_LOCKS))
		else $error("queue fill above the number of locks");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != '0) |-> (qid_q[0] != '0 && qid_q[0] <= ID_W'(NUM_LOCKS)))
		else $error("queue head holds no lock id");

	a_drive_cool: assert property (@(posedge clk) disable iff (!arst_n)
		(dl_q & ca_q) == '0)
		else $error("lock driven while its cooldown runs");

endmodule
`default_nettype wire

[sv/queued_solenoid_pulse_sequencer.sv]
// Queued solenoid pulse sequencer, top level.
// Joins the controller qsps_ctrl and the datapath qsps_dp; depends on qsps_pkg.
//
// Input channel s_*: one item is a timer tick (s_tuser low) or an unlock request
// (s_tuser high) whose lock mask is in s_tdata. Every item yields exactly one result
// item on m_*, holding the drive levels, queue count, queue head id and cooldown
// flags as they stand after the item.
// The configuration port writes pulse_ticks, between_ticks and self_lock_ticks at
// cfg_idx 0, 1 and 2 on any edge with cfg_we high; write it only while the block is
// idle. Other indexes are ignored.
// An item is worked on in one cycle per lock, handled in order, by one shared lock
// unit: after the accepting edge it passes one step per lock and then the load step,
// which sets m_tvalid; no new item is accepted until the block is idle again.
// The result register lets the next item be accepted while a result still waits;
// if the receiver stalls longer, the block holds that next item in its load step,
// accepting nothing, until the result register frees.
// Reset clears the queue, all timers and drive levels, and loads the register
// defaults of 2, 6 and 20 ticks. The block is ready in the first cycle after reset.
`default_nettype none
module queued_solenoid_pulse_sequencer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [qsps_pkg::SDATA_W-1:0]   s_tdata,  // [3:0] lock_mask
	input  wire logic                           s_tuser,  // [0] opcode
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [3:0] drive_mask, [6:4] queue_count, [9:7] head_lock, [13:10] cooldown_mask
	output logic [qsps_pkg::MDATA_W-1:0]        m_tdata,
	input  wire logic                           cfg_we,
	input  wire logic [qsps_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [qsps_pkg::CFG_W-1:0]     cfg_data
);
	import qsps_pkg::*;

	cmd_t cmd;
	sts_t sts;

	qsps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	qsps_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
`default_nettype wire
